### hdl/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants of the RPN stack evaluator
// Field widths, token and status codes, stack geometry, iteration counts and
// the command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package rse_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Number format: signed fixed point with FRAC_BITS fraction bits.
    localparam int VAL_W     = 48;
    localparam int FRAC_BITS = 16;
    localparam int MAG_W     = 2 * VAL_W;
    localparam int DIV_W     = VAL_W + FRAC_BITS;

    localparam int MODE_W = 3;
    localparam int STAT_W = 3;

    // Iteration counts of the shared shift-add and shift-subtract units.
    localparam int MUL_STEPS = VAL_W;
    localparam int DIV_STEPS = DIV_W;
    localparam int ITER_W    = $clog2(DIV_STEPS);

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0]        MIN_MAG = {1'b1, {(VAL_W-1){1'b0}}};

    // Token codes.
    localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MISSING    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_INCOMPLETE = 3'd3;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_DIVZERO    = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_SAT,
        S_COMMIT
    } rse_state_t;

    // How the current token is computed.
    typedef enum logic [1:0] {
        CLS_SIMPLE,
        CLS_MUL,
        CLS_DIV
    } rse_cls_t;

    typedef struct packed {
        logic tok_load;
        logic exec_load;
        logic mul_step;
        logic div_step;
        logic sat_load;
        logic commit;
    } rse_cmd_t;

    typedef struct packed {
        rse_cls_t cls;
        logic     out_busy;
    } rse_status_t;

endpackage

### hdl/rse_if.sv
// ----------------------------------------------------------------------------
// rse_if: token and result channels of the RPN stack evaluator
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rse_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [rse_pkg::MODE_W-1:0]           mode;
    logic signed [rse_pkg::VAL_W-1:0]     number;
    logic                                 end_of_expr;

    modport source (output valid, output mode, output number, output end_of_expr,
                    input ready);
    modport sink   (input valid, input mode, input number, input end_of_expr,
                    output ready);
endinterface

interface rse_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rse_pkg::VAL_W-1:0]     value;
    logic [rse_pkg::STAT_W-1:0]           status;
    logic                                 final_res;

    modport source (output valid, output value, output status, output final_res,
                    input ready);
    modport sink   (input valid, input value, input status, input final_res,
                    output ready);
endinterface

### hdl/rse_datapath.sv
// ----------------------------------------------------------------------------
// rse_datapath: operand stack, arithmetic units and result register
// Holds the top of stack in a register and the entries below it in a memory,
// a shift-add multiplier, a restoring divider and the output register.
// ----------------------------------------------------------------------------
module rse_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rse_pkg::rse_cmd_t                cmd,
    output rse_pkg::rse_status_t             status,
    input  logic [rse_pkg::MODE_W-1:0]       mode,
    input  logic signed [rse_pkg::VAL_W-1:0] number,
    input  logic                             end_of_expr,
    rse_out_if.source                        out_ch
);

    localparam int VAL_W  = rse_pkg::VAL_W;
    localparam int MAG_W  = rse_pkg::MAG_W;
    localparam int DIV_W  = rse_pkg::DIV_W;
    localparam int CNT_W  = rse_pkg::CNT_W;
    localparam int ADDR_W = rse_pkg::ADDR_W;
    localparam int STAT_W = rse_pkg::STAT_W;

    // Saturate a sum or difference with one guard bit to the value range.
    function automatic logic [VAL_W-1:0] sat_sum(input logic [VAL_W:0] sum);
        logic [VAL_W-1:0] res;
        if (sum[VAL_W] != sum[VAL_W-1])
        begin
            res = sum[VAL_W] ? rse_pkg::VAL_MIN : rse_pkg::VAL_MAX;
        end
        else
        begin
            res = sum[VAL_W-1:0];
        end
        return res;
    endfunction

    // Apply the sign to a wide magnitude, saturating to the value range.
    function automatic logic [VAL_W-1:0] sat_mag(input logic [MAG_W-1:0] mag,
                                                 input logic neg);
        logic             hi_any;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] res;
        hi_any = |mag[MAG_W-1:VAL_W];
        lo     = mag[VAL_W-1:0];
        if (neg)
        begin
            res = (hi_any || (lo > rse_pkg::MIN_MAG)) ? rse_pkg::VAL_MIN
                                                      : (~lo + VAL_W'(1));
        end
        else
        begin
            res = (hi_any || lo[VAL_W-1]) ? rse_pkg::VAL_MAX : lo;
        end
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
    endfunction

    // Operand stack below the top-of-stack register.
    logic [VAL_W-1:0] stack_mem [0:rse_pkg::STACK_DEPTH-1];

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [STAT_W-1:0] err_reg, err_next;
    logic              out_valid_reg, out_valid_next;

    logic [VAL_W-1:0]  tos_reg;
    logic [VAL_W-1:0]  rd_reg;
    logic [rse_pkg::MODE_W-1:0] mode_reg;
    logic [VAL_W-1:0]  number_reg;
    logic              last_reg;
    logic [VAL_W-1:0]  res_reg;
    logic [STAT_W-1:0] err_pend_reg;
    logic              dz_reg;
    logic              neg_reg;
    logic [MAG_W-1:0]  prod_reg;
    logic [VAL_W-1:0]  mcand_reg;
    logic [VAL_W:0]    rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [VAL_W-1:0]  dvs_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_final_reg;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              is_push;
    logic              stack_wr;

    logic [STAT_W-1:0] err_exec;
    logic              b_zero;
    logic              dz_exec;
    logic [VAL_W-1:0]  simple_res;
    logic [VAL_W-1:0]  mag_a;
    logic [VAL_W-1:0]  mag_b;
    logic [VAL_W:0]    add_sum;
    logic [VAL_W:0]    sub_sum;

    logic [VAL_W:0]    mul_sum;
    logic [VAL_W:0]    div_shift;
    logic              div_ge;
    logic [MAG_W-1:0]  sat_in;

    logic [CNT_W-1:0]  cnt_op;
    logic [VAL_W-1:0]  commit_value;
    logic [STAT_W-1:0] commit_status;

    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign cnt_m2  = cnt_reg - CNT_W'(2);
    assign rd_addr = cnt_m2[ADDR_W-1:0];
    assign wr_addr = cnt_m1[ADDR_W-1:0];
    assign is_push = (mode_reg == rse_pkg::MODE_PUSH);

    // Error check of the latched token against the sticky error and the count.
    always_comb
    begin
        err_exec = rse_pkg::STAT_OK;
        if (err_reg != rse_pkg::STAT_OK)
        begin
            err_exec = err_reg;
        end
        else
        begin
            case (mode_reg)
                rse_pkg::MODE_PUSH:
                begin
                    if (cnt_reg >= CNT_W'(rse_pkg::STACK_DEPTH))
                    begin
                        err_exec = rse_pkg::STAT_OVERFLOW;
                    end
                end
                rse_pkg::MODE_ADD, rse_pkg::MODE_SUB,
                rse_pkg::MODE_MUL, rse_pkg::MODE_DIV:
                begin
                    if (cnt_reg < CNT_W'(2))
                    begin
                        err_exec = rse_pkg::STAT_MISSING;
                    end
                end
                default:
                begin
                    err_exec = rse_pkg::STAT_INVALID;
                end
            endcase
        end
    end

    // Results that need no iteration: push, add, subtract, divide by zero.
    assign b_zero  = (tos_reg == '0);
    assign add_sum = {rd_reg[VAL_W-1], rd_reg} + {tos_reg[VAL_W-1], tos_reg};
    assign sub_sum = {rd_reg[VAL_W-1], rd_reg} - {tos_reg[VAL_W-1], tos_reg};
    assign mag_a   = magnitude(rd_reg);
    assign mag_b   = magnitude(tos_reg);
    assign dz_exec = (err_exec == rse_pkg::STAT_OK) && (mode_reg == rse_pkg::MODE_DIV)
                     && b_zero;

    always_comb
    begin
        case (mode_reg)
            rse_pkg::MODE_PUSH: simple_res = number_reg;
            rse_pkg::MODE_ADD:  simple_res = sat_sum(add_sum);
            rse_pkg::MODE_SUB:  simple_res = sat_sum(sub_sum);
            rse_pkg::MODE_DIV:
            begin
                if (rd_reg[VAL_W-1])
                begin
                    simple_res = rse_pkg::VAL_MIN;
                end
                else if (rd_reg != '0)
                begin
                    simple_res = rse_pkg::VAL_MAX;
                end
                else
                begin
                    simple_res = '0;
                end
            end
            default:            simple_res = '0;
        endcase
    end

    // Status toward the controller: token class and output back-pressure.
    always_comb
    begin
        status.cls      = rse_pkg::CLS_SIMPLE;
        status.out_busy = out_valid_reg && !out_ch.ready;
        if ((err_exec == rse_pkg::STAT_OK) && (mode_reg == rse_pkg::MODE_MUL))
        begin
            status.cls = rse_pkg::CLS_MUL;
        end
        else if ((err_exec == rse_pkg::STAT_OK) && (mode_reg == rse_pkg::MODE_DIV)
                 && !b_zero)
        begin
            status.cls = rse_pkg::CLS_DIV;
        end
    end

    // One shift-add step: add the multiplicand when the low bit is set.
    assign mul_sum = {1'b0, prod_reg[MAG_W-1:VAL_W]}
                     + (prod_reg[0] ? {1'b0, mcand_reg} : {(VAL_W+1){1'b0}});

    // One restoring division step: bring in the next numerator bit.
    assign div_shift = {rem_reg[VAL_W-1:0], quo_reg[DIV_W-1]};
    assign div_ge    = (div_shift >= {1'b0, dvs_reg});

    always_comb
    begin
        if (mode_reg == rse_pkg::MODE_MUL)
        begin
            sat_in = prod_reg >> rse_pkg::FRAC_BITS;
        end
        else
        begin
            sat_in = MAG_W'(quo_reg);
        end
    end

    // Stack, error and output update when the token is finished.
    always_comb
    begin
        cnt_op        = is_push ? (cnt_reg + CNT_W'(1)) : cnt_m1;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        commit_value  = '0;
        commit_status = err_pend_reg;
        stack_wr      = 1'b0;
        if (err_pend_reg == rse_pkg::STAT_OK)
        begin
            cnt_next      = cnt_op;
            commit_value  = res_reg;
            commit_status = dz_reg ? rse_pkg::STAT_DIVZERO : rse_pkg::STAT_OK;
            stack_wr      = is_push && (cnt_reg != '0);
            if (last_reg && (cnt_op != CNT_W'(1)))
            begin
                commit_value  = '0;
                commit_status = rse_pkg::STAT_INCOMPLETE;
            end
        end
        if (last_reg)
        begin
            cnt_next = '0;
            err_next = rse_pkg::STAT_OK;
        end
        else
        begin
            err_next = err_pend_reg;
        end
        if (!cmd.commit)
        begin
            cnt_next = cnt_reg;
            err_next = err_reg;
            stack_wr = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            err_reg       <= rse_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stack memory: written on a push, read for the lower operand.
    always_ff @(posedge clk)
    begin
        if (stack_wr)
        begin
            stack_mem[wr_addr] <= tos_reg;
        end
        if (cmd.tok_load)
        begin
            rd_reg <= stack_mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.tok_load)
        begin
            mode_reg   <= mode;
            number_reg <= number;
            last_reg   <= end_of_expr;
        end
        if (cmd.exec_load)
        begin
            res_reg      <= simple_res;
            err_pend_reg <= err_exec;
            dz_reg       <= dz_exec;
            neg_reg      <= rd_reg[VAL_W-1] ^ tos_reg[VAL_W-1];
            prod_reg     <= {{VAL_W{1'b0}}, mag_b};
            mcand_reg    <= mag_a;
            rem_reg      <= '0;
            quo_reg      <= DIV_W'(mag_a) << rse_pkg::FRAC_BITS;
            dvs_reg      <= mag_b;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= {mul_sum, prod_reg[VAL_W-1:1]};
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? (div_shift - {1'b0, dvs_reg}) : div_shift;
            quo_reg <= {quo_reg[DIV_W-2:0], div_ge};
        end
        if (cmd.sat_load)
        begin
            res_reg <= sat_mag(sat_in, neg_reg);
        end
        if (cmd.commit)
        begin
            if ((err_pend_reg == rse_pkg::STAT_OK) && (cnt_reg != '0 || is_push))
            begin
                tos_reg <= res_reg;
            end
            out_value_reg  <= commit_value;
            out_status_reg <= commit_status;
            out_final_reg  <= last_reg;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.value     = out_value_reg;
    assign out_ch.status    = out_status_reg;
    assign out_ch.final_res = out_final_reg;

    // The count never passes the stack depth.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(rse_pkg::STACK_DEPTH))
        else $error("stack count above depth");

    // A finished token is always presented on the output.
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("finished token not presented");

    // The last token of an expression leaves an empty, error-free stack.
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && last_reg) |=> ((cnt_reg == '0) && (err_reg == rse_pkg::STAT_OK)))
        else $error("expression not closed");

endmodule

### hdl/rse_controller.sv
// ----------------------------------------------------------------------------
// rse_controller: sequencer of the RPN stack evaluator
// Accepts one token, steps the multiplier or divider and finishes the token
// once the output register is free.
// ----------------------------------------------------------------------------
module rse_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rse_pkg::rse_status_t status,
    output rse_pkg::rse_cmd_t    cmd
);

    localparam int ITER_W = rse_pkg::ITER_W;

    rse_pkg::rse_state_t state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;

    // State and iteration counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rse_pkg::S_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            rse_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.tok_load = 1'b1;
                    state_next   = rse_pkg::S_EXEC;
                end
            end
            rse_pkg::S_EXEC:
            begin
                cmd.exec_load = 1'b1;
                iter_next     = '0;
                case (status.cls)
                    rse_pkg::CLS_MUL: state_next = rse_pkg::S_MUL;
                    rse_pkg::CLS_DIV: state_next = rse_pkg::S_DIV;
                    default:          state_next = rse_pkg::S_COMMIT;
                endcase
            end
            rse_pkg::S_MUL:
            begin
                cmd.mul_step = 1'b1;
                iter_next    = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(rse_pkg::MUL_STEPS - 1))
                begin
                    state_next = rse_pkg::S_SAT;
                end
            end
            rse_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(rse_pkg::DIV_STEPS - 1))
                begin
                    state_next = rse_pkg::S_SAT;
                end
            end
            rse_pkg::S_SAT:
            begin
                cmd.sat_load = 1'b1;
                state_next   = rse_pkg::S_COMMIT;
            end
            rse_pkg::S_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = rse_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rse_pkg::S_IDLE;
            end
        endcase
    end

    // No new token is taken while one is in flight.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rse_pkg::S_IDLE) |-> !cmd.tok_load)
        else $error("token accepted while busy");

    // A finished token waits while the output register is still full.
    a_commit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == rse_pkg::S_COMMIT) && status.out_busy)
        |=> (state_reg == rse_pkg::S_COMMIT))
        else $error("finish did not wait for output");

endmodule

### hdl/rpn_stack_evaluator_top.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top: reverse Polish expression evaluator
// Evaluates tokens of one expression on a stack of signed Q31.16 values.
//
//   Channel   Direction  Payload
//   in_ch     sink       mode, number, end_of_expr
//   out_ch    source     value, status, final_res
//
// A push, add, subtract, divide by zero or error token needs no iteration; a
// multiply runs 48 shift-add steps and a divide makes one quotient bit per
// cycle, and both then saturate their result in S_SAT.
// Reset clears the stack count and sticky error; the stack memory needs no
// clearing since only written entries are read.
// A stalled output holds the finished token; one more token is taken and
// worked on while the result waits, then it waits to be finished.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_top (
    input  logic      clk,
    input  logic      rst_n,
    rse_in_if.sink    in_ch,
    rse_out_if.source out_ch
);

    rse_pkg::rse_cmd_t    cmd;
    rse_pkg::rse_status_t status;
    logic                 ctrl_ready;

    assign in_ch.ready = ctrl_ready;

    // Sequencer.
    rse_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ctrl_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Stack and arithmetic.
    rse_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (in_ch.mode),
        .number      (in_ch.number),
        .end_of_expr (in_ch.end_of_expr),
        .out_ch      (out_ch)
    );

endmodule

### tb/rpn_stack_evaluator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top_tb: self-checking bench for the RPN stack evaluator
// Sends tokens of directed and random reverse Polish expressions, predicts
// each result with a shadow stack kept in the bench, and compares every
// returned result field by field. Both channels idle at random in bursts.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_top_tb;

    localparam int VAL_W        = rse_pkg::VAL_W;
    localparam int MODE_W       = rse_pkg::MODE_W;
    localparam int STAT_W       = rse_pkg::STAT_W;
    localparam int FRAC_BITS    = rse_pkg::FRAC_BITS;
    localparam int STACK_DEPTH  = rse_pkg::STACK_DEPTH;
    localparam int WIDE_W       = rse_pkg::MAG_W + rse_pkg::FRAC_BITS;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 100;

    // Token codes outside the operator set.
    localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;

    typedef logic signed [VAL_W-1:0] fx_t;

    localparam fx_t FX_ONE = fx_t'(1) << FRAC_BITS;

    typedef struct packed {
        fx_t               value;
        logic [STAT_W-1:0] status;
        logic              final_res;
    } result_t;

    logic clk;
    logic rst_n;

    rse_in_if  in_ch ();
    rse_out_if out_ch ();

    rpn_stack_evaluator_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow copy of the evaluator state.
    fx_t               shadow_stack [STACK_DEPTH];
    int                shadow_depth;
    logic [STAT_W-1:0] shadow_error;

    result_t expected_results [$];
    int      error_count;
    int      token_count;
    int      stall_cycles;
    bit      idling_on;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Magnitude of a value; the most negative value gives 2^47.
    function automatic logic [VAL_W-1:0] magnitude_of(fx_t v);
        logic [VAL_W-1:0] u;
        u = v;
        return v[VAL_W-1] ? (~u + VAL_W'(1)) : u;
    endfunction

    // Applies the sign to a wide magnitude and saturates to the value range.
    function automatic fx_t signed_saturate(logic [WIDE_W-1:0] m, bit neg);
        logic [WIDE_W-1:0] lim_neg;
        logic [WIDE_W-1:0] lim_pos;
        logic [VAL_W-1:0]  low;
        lim_neg = WIDE_W'(rse_pkg::MIN_MAG);
        lim_pos = WIDE_W'(rse_pkg::VAL_MAX);
        low     = m[VAL_W-1:0];
        if (neg)
        begin
            if (m > lim_neg)
                return rse_pkg::VAL_MIN;
            return fx_t'(~low + VAL_W'(1));
        end
        if (m > lim_pos)
            return rse_pkg::VAL_MAX;
        return fx_t'(low);
    endfunction

    // Computes the result of one accepted token and updates the shadow state.
    function automatic result_t eval_token(logic [MODE_W-1:0] mode, fx_t num, logic last);
        result_t                r;
        fx_t                    lhs;
        fx_t                    rhs;
        fx_t                    res;
        logic signed [VAL_W:0]  sum_w;
        logic [WIDE_W-1:0]      mag_a;
        logic [WIDE_W-1:0]      mag_b;
        logic [WIDE_W-1:0]      wide;
        bit                     neg;
        r.value     = '0;
        r.status    = rse_pkg::STAT_OK;
        r.final_res = last;
        res         = '0;
        if (shadow_error == rse_pkg::STAT_OK)
        begin
            if (mode == rse_pkg::MODE_PUSH)
            begin
                if (shadow_depth >= STACK_DEPTH)
                    shadow_error = rse_pkg::STAT_OVERFLOW;
                else
                begin
                    shadow_stack[shadow_depth] = num;
                    shadow_depth++;
                    r.value = num;
                end
            end
            else if (mode <= rse_pkg::MODE_DIV)
            begin
                if (shadow_depth < 2)
                    shadow_error = rse_pkg::STAT_MISSING;
                else
                begin
                    rhs   = shadow_stack[shadow_depth-1];
                    lhs   = shadow_stack[shadow_depth-2];
                    mag_a = WIDE_W'(magnitude_of(lhs));
                    mag_b = WIDE_W'(magnitude_of(rhs));
                    neg   = lhs[VAL_W-1] ^ rhs[VAL_W-1];
                    case (mode)
                        rse_pkg::MODE_ADD, rse_pkg::MODE_SUB:
                        begin
                            if (mode == rse_pkg::MODE_ADD)
                                sum_w = (VAL_W+1)'(lhs) + (VAL_W+1)'(rhs);
                            else
                                sum_w = (VAL_W+1)'(lhs) - (VAL_W+1)'(rhs);
                            if (sum_w > rse_pkg::VAL_MAX)
                                res = rse_pkg::VAL_MAX;
                            else if (sum_w < rse_pkg::VAL_MIN)
                                res = rse_pkg::VAL_MIN;
                            else
                                res = sum_w[VAL_W-1:0];
                        end
                        rse_pkg::MODE_MUL:
                        begin
                            wide = (mag_a * mag_b) >> FRAC_BITS;
                            res  = signed_saturate(wide, neg);
                        end
                        default:
                        begin
                            if (rhs == '0)
                            begin
                                // Division by zero saturates by the dividend's sign.
                                if (lhs > 0)
                                    res = rse_pkg::VAL_MAX;
                                else if (lhs < 0)
                                    res = rse_pkg::VAL_MIN;
                                else
                                    res = '0;
                                r.status = rse_pkg::STAT_DIVZERO;
                            end
                            else
                            begin
                                wide = (mag_a << FRAC_BITS) / mag_b;
                                res  = signed_saturate(wide, neg);
                            end
                        end
                    endcase
                    shadow_depth -= 1;
                    shadow_stack[shadow_depth-1] = res;
                    r.value = res;
                end
            end
            else
                shadow_error = rse_pkg::STAT_INVALID;
        end

        // A sticky error masks the token.
        if (shadow_error != rse_pkg::STAT_OK)
        begin
            r.value  = '0;
            r.status = shadow_error;
        end

        // The last token closes the expression.
        if (last)
        begin
            if (shadow_error == rse_pkg::STAT_OK)
            begin
                if (shadow_depth != 1)
                begin
                    r.status = rse_pkg::STAT_INCOMPLETE;
                    r.value  = '0;
                end
                else
                    r.value = shadow_stack[0];
            end
            shadow_depth = 0;
            shadow_error = rse_pkg::STAT_OK;
        end
        return r;
    endfunction

    // Random value biased toward zero, the extremes and moderate magnitudes.
    function automatic fx_t rand_fx();
        logic [63:0] bits;
        fx_t         v;
        bits = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = rse_pkg::VAL_MAX;
            2:       v = rse_pkg::VAL_MIN;
            3:       v = bits[0] ? fx_t'(1) : -fx_t'(1);
            4, 5:    v = bits[VAL_W-1:0];
            6, 7:    v = {{(VAL_W-21){bits[20]}}, bits[20:0]};
            default: v = {{(VAL_W-32){bits[31]}}, bits[31:0]};
        endcase
        return v;
    endfunction

    // Sends one token, waits for its acceptance and records its expected result.
    task automatic send_token(logic [MODE_W-1:0] mode, fx_t num, logic last);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.number      <= num;
        in_ch.end_of_expr <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_results.push_back(eval_token(mode, num, last));
        token_count++;
    endtask

    // Each operator on moderate operands.
    task automatic test_basic_arithmetic();
        send_token(rse_pkg::MODE_PUSH, FX_ONE * 7 / 2, 1'b0);
        send_token(rse_pkg::MODE_PUSH, FX_ONE * 5 / 4, 1'b0);
        send_token(rse_pkg::MODE_MUL, '0, 1'b0);
        send_token(rse_pkg::MODE_PUSH, -FX_ONE * 2, 1'b0);
        send_token(rse_pkg::MODE_DIV, '0, 1'b0);
        send_token(rse_pkg::MODE_PUSH, FX_ONE * 3 / 4, 1'b0);
        send_token(rse_pkg::MODE_SUB, '0, 1'b0);
        send_token(rse_pkg::MODE_PUSH, fx_t'(1), 1'b0);
        send_token(rse_pkg::MODE_ADD, '0, 1'b1);
    endtask

    // Every operator driven past an end of the range: add, subtract and multiply past the top, divide past the bottom.
    task automatic test_saturation();
        send_token(rse_pkg::MODE_PUSH, rse_pkg::VAL_MAX, 1'b0);
        send_token(rse_pkg::MODE_PUSH, FX_ONE, 1'b0);
        send_token(rse_pkg::MODE_ADD, '0, 1'b0);
        send_token(rse_pkg::MODE_PUSH, rse_pkg::VAL_MIN, 1'b0);
        send_token(rse_pkg::MODE_SUB, '0, 1'b0);
        send_token(rse_pkg::MODE_PUSH, -FX_ONE / 2, 1'b0);
        send_token(rse_pkg::MODE_DIV, '0, 1'b0);
        send_token(rse_pkg::MODE_PUSH, -FX_ONE, 1'b0);
        send_token(rse_pkg::MODE_MUL, '0, 1'b1);
    endtask

    // Division by zero with positive, negative and zero dividends.
    task automatic test_divide_by_zero();
        send_token(rse_pkg::MODE_PUSH, FX_ONE * 5, 1'b0);
        send_token(rse_pkg::MODE_PUSH, '0, 1'b0);
        send_token(rse_pkg::MODE_DIV, '0, 1'b1);
        send_token(rse_pkg::MODE_PUSH, -FX_ONE * 3, 1'b0);
        send_token(rse_pkg::MODE_PUSH, '0, 1'b0);
        send_token(rse_pkg::MODE_DIV, '0, 1'b0);
        send_token(rse_pkg::MODE_PUSH, '0, 1'b0);
        send_token(rse_pkg::MODE_PUSH, '0, 1'b0);
        send_token(rse_pkg::MODE_DIV, '0, 1'b0);
        send_token(rse_pkg::MODE_SUB, '0, 1'b1);
    endtask

    // Missing operands, invalid codes, a sticky error and an incomplete stack.
    task automatic test_token_errors();
        send_token(rse_pkg::MODE_ADD, '0, 1'b1);
        send_token(rse_pkg::MODE_PUSH, FX_ONE, 1'b0);
        send_token(rse_pkg::MODE_MUL, '0, 1'b0);
        send_token(rse_pkg::MODE_PUSH, FX_ONE, 1'b1);
        for (int m = MODE_BAD_LO; m <= MODE_BAD_HI; m++)
            send_token(m[MODE_W-1:0], FX_ONE, 1'b1);
        send_token(rse_pkg::MODE_PUSH, rse_pkg::VAL_MAX, 1'b0);
        send_token(rse_pkg::MODE_PUSH, rse_pkg::VAL_MIN, 1'b1);
    endtask

    // Fills the stack, then one push too many sets the overflow error.
    task automatic test_stack_overflow();
        for (int i = 0; i < STACK_DEPTH; i++)
            send_token(rse_pkg::MODE_PUSH, rand_fx(), 1'b0);
        send_token(rse_pkg::MODE_PUSH, rand_fx(), 1'b0);
        send_token(rse_pkg::MODE_ADD, '0, 1'b0);
        send_token(rse_pkg::MODE_PUSH, rand_fx(), 1'b1);
    endtask

    // One random expression; a broken one has a single token replaced by noise.
    task automatic send_random_expr(bit broken);
        int               pushes_left;
        int               depth;
        int               tok_idx;
        int               noise_idx;
        bit               do_op;
        logic [MODE_W-1:0] mode;
        fx_t              num;
        logic             last;
        pushes_left = $urandom_range(1, 12);
        depth       = 0;
        tok_idx     = 0;
        noise_idx   = broken ? int'($urandom_range(0, 2 * pushes_left - 2)) : -1;
        while (pushes_left > 0 || depth > 1)
        begin
            do_op = depth >= 2 && (pushes_left == 0 || $urandom_range(0, 1) == 1);
            if (do_op)
            begin
                mode  = MODE_W'($urandom_range(rse_pkg::MODE_ADD, rse_pkg::MODE_DIV));
                num   = rand_fx();
                depth = depth - 1;
            end
            else
            begin
                mode        = rse_pkg::MODE_PUSH;
                num         = rand_fx();
                pushes_left = pushes_left - 1;
                depth       = depth + 1;
            end
            last = pushes_left == 0 && depth == 1;
            if (tok_idx == noise_idx)
            begin
                mode = MODE_W'($urandom_range(0, 7));
                last = 1'($urandom_range(0, 1));
            end
            send_token(mode, num, last);
            tok_idx++;
        end
    endtask

    // Random expressions until the token count reaches the target.
    task automatic test_random_expressions(int target);
        while (token_count < target)
            send_random_expr($urandom_range(0, 4) == 0);
    endtask

    // Output side: ready drops in random bursts while idling is on.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (idling_on && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Compares each returned result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: value %0d status %0d final_res %0b",
                       out_ch.value, out_ch.status, out_ch.final_res);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, out_ch.value);
                    error_count++;
                end
                if (out_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_ch.status);
                    error_count++;
                end
                if (out_ch.final_res !== want.final_res)
                begin
                    $error("final_res: expected %0b, got %0b", want.final_res,
                           out_ch.final_res);
                    error_count++;
                end
            end
        end
    end

    // Ends the run when no request moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("rpn_stack_evaluator_top_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.mode        <= rse_pkg::MODE_PUSH;
        in_ch.number      <= '0;
        in_ch.end_of_expr <= 1'b0;
        shadow_depth      = 0;
        shadow_error      = rse_pkg::STAT_OK;
        error_count       = 0;
        token_count       = 0;
        stall_cycles      = 0;
        idling_on         = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_arithmetic();
        test_saturation();
        test_divide_by_zero();
        test_token_errors();
        test_stack_overflow();
        test_random_expressions(950);
        idling_on = 1'b0;
        test_random_expressions(1050);
        in_ch.valid <= 1'b0;

        // Drain the outstanding results, then let the block settle.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("rpn_stack_evaluator_top_tb: done, clean");
        else
            $display("rpn_stack_evaluator_top_tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
hdl/rse_pkg.sv
hdl/rse_if.sv
hdl/rse_datapath.sv
hdl/rse_controller.sv
hdl/rpn_stack_evaluator_top.sv
tb/rpn_stack_evaluator_top_tb.sv
